@@ hdl/dcpu_pkg.sv @@
// Shared types, constants and decode tables for the DCPU-16 core.
package dcpu_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = 65536;

  typedef enum logic [2:0] {
    KIND_WR_MEM = 3'd0,
    KIND_RD_MEM = 3'd1,
    KIND_STEP   = 3'd2,
    KIND_INT    = 3'd3,
    KIND_RD_REG = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    CS_RUN  = 2'd0,
    CS_HALT = 2'd1,
    CS_FIRE = 2'd2
  } core_state_t;

  // Register numbers for register reads.
  localparam logic [15:0] REG_PC = 16'd8;
  localparam logic [15:0] REG_SP = 16'd9;
  localparam logic [15:0] REG_EX = 16'd10;
  localparam logic [15:0] REG_IA = 16'd11;

  // Basic opcodes.
  localparam logic [4:0] OP_SET = 5'h01, OP_ADD = 5'h02, OP_SUB = 5'h03, OP_MUL = 5'h04,
                         OP_MLI = 5'h05, OP_DIV = 5'h06, OP_DVI = 5'h07, OP_MOD = 5'h08,
                         OP_MDI = 5'h09, OP_AND = 5'h0A, OP_BOR = 5'h0B, OP_XOR = 5'h0C,
                         OP_SHR = 5'h0D, OP_ASR = 5'h0E, OP_SHL = 5'h0F, OP_IFB = 5'h10,
                         OP_IFC = 5'h11, OP_IFE = 5'h12, OP_IFN = 5'h13, OP_IFG = 5'h14,
                         OP_IFA = 5'h15, OP_IFL = 5'h16, OP_IFU = 5'h17, OP_ADX = 5'h1A,
                         OP_SBX = 5'h1B, OP_STI = 5'h1E, OP_STD = 5'h1F;

  // Special opcodes.
  localparam logic [4:0] SOP_JSR = 5'h01, SOP_INT = 5'h08, SOP_IAG = 5'h09, SOP_IAS = 5'h0A,
                         SOP_RFI = 5'h0B, SOP_IAQ = 5'h0C, SOP_HWN = 5'h10, SOP_HWQ = 5'h11,
                         SOP_HWI = 5'h12;

  // Operand codes with a fixed meaning.
  localparam logic [5:0] OPD_PUSH_POP = 6'h18, OPD_PEEK = 6'h19, OPD_PICK = 6'h1A,
                         OPD_SP = 6'h1B, OPD_PC = 6'h1C, OPD_EX = 6'h1D,
                         OPD_IND_NW = 6'h1E, OPD_LIT_NW = 6'h1F, OPD_LIT_BASE = 6'h21;

  typedef enum logic [2:0] {LK_REG, LK_PC, LK_SP, LK_EX, LK_MEM, LK_NONE} loc_kind_t;

  typedef struct packed {
    loc_kind_t   kind;
    logic [2:0]  idx;
    logic [15:0] addr;
  } loc_t;

  function automatic logic [1:0] basic_cost(input logic [4:0] op);
    logic [1:0] c;
    case (op)
      OP_SET, OP_AND, OP_BOR, OP_XOR, OP_SHR, OP_ASR, OP_SHL: c = 2'd1;
      OP_ADD, OP_SUB, OP_MUL, OP_MLI, OP_STI, OP_STD: c = 2'd2;
      OP_IFB, OP_IFC, OP_IFE, OP_IFN, OP_IFG, OP_IFA, OP_IFL, OP_IFU: c = 2'd2;
      OP_DIV, OP_DVI, OP_MOD, OP_MDI, OP_ADX, OP_SBX: c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] special_cost(input logic [4:0] op);
    logic [2:0] c;
    case (op)
      SOP_JSR, SOP_RFI: c = 3'd3;
      SOP_INT, SOP_HWQ, SOP_HWI: c = 3'd4;
      SOP_IAG, SOP_IAS: c = 3'd1;
      SOP_IAQ, SOP_HWN: c = 3'd2;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  // True where an operand code takes a next word from the instruction stream.
  function automatic logic needs_word(input logic [5:0] code);
    return (code >= 6'h10 && code <= 6'h17) || code == OPD_PICK ||
           code == OPD_IND_NW || code == OPD_LIT_NW;
  endfunction

endpackage

@@ hdl/dcpu_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module dcpu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/dcpu16_processor_core_unit.sv @@
// Top level of the DCPU-16 core: sequencer, register file and the two memories.
//
// One transaction in gives one transaction out. A memory write or register read goes
// straight to S_DONE, a memory read through S_RDMEM first. A step has the fetch, then each
// operand (one more state each for a next word and for a memory operand), then execute, plus
// a division for DIV, DVI, MOD and MDI by a nonzero divisor (one quotient bit a cycle) and
// a read of each skipped instruction; taking a queued interrupt adds S_QRD, S_RAISE and,
// with IA nonzero, S_RAISE2. The main memory has a single read port with registered data.
// A finished result waits in the output register while the next transaction is accepted.
module dcpu16_processor_core_unit import dcpu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] address, [31:16] data
  input  logic [2:0]  in_tuser,   // [2:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [15:0] read_data, [31:16] pc_after, [33:32] run_state,
                                  // [65:34] cycle_total, [71:66] zero
);

  typedef enum logic [4:0] {
    S_IDLE, S_RDMEM, S_QRD, S_FETCH, S_FETCH_W, S_OP, S_OP_NW, S_OP_MEM, S_EXEC,
    S_DIV, S_DIV_WB, S_SKIP, S_SKIP_W, S_RFI1, S_RFI2, S_RAISE, S_RAISE2, S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [15:0]      regs_r [8];
  logic [15:0]      regs_nxt [8];
  logic [15:0]      pc_r, pc_nxt, sp_r, sp_nxt, ex_r, ex_nxt, ia_r, ia_nxt;
  logic [QIDX_W-1:0] qhead_r, qhead_nxt;
  logic [QCNT_W-1:0] qcount_r, qcount_nxt;
  logic             qon_r, qon_nxt;
  core_state_t      core_r, core_nxt;
  logic [31:0]      cyc_r, cyc_nxt;
  logic [15:0]      word_r, word_nxt;
  logic             opsel_r, opsel_nxt;
  logic [5:0]       code_r, code_nxt;
  loc_t             a_loc_r, a_loc_nxt, b_loc_r, b_loc_nxt;
  logic [15:0]      a_val_r, a_val_nxt, b_val_r, b_val_nxt;
  logic [15:0]      rd_r, rd_nxt, msg_r, msg_nxt;
  logic             ret_fetch_r, ret_fetch_nxt;
  logic [15:0]      skip_n_r, skip_n_nxt;
  logic [31:0]      dvd_r, dvd_nxt;
  logic [15:0]      rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [4:0]       div_cnt_r, div_cnt_nxt;
  logic             neg_r, neg_nxt, bneg_r, bneg_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      out_rd_r, out_rd_nxt, out_pc_r, out_pc_nxt;
  logic [1:0]       out_st_r, out_st_nxt;
  logic [31:0]      out_cyc_r, out_cyc_nxt;

  // Memory ports.
  logic             mem_we;
  logic [15:0]      mem_waddr, mem_wdata, mem_raddr, mem_rdata;
  logic             q_we;
  logic [QIDX_W-1:0] q_waddr;
  logic [15:0]      q_wdata, q_rdata;

  // Register file read port and location write port.
  logic [2:0]       reg_sel;
  logic [15:0]      reg_rd;
  logic             wr_en;
  loc_t             wr_loc;
  logic [15:0]      wr_val;
  logic             fin;
  loc_t             fin_loc;
  logic [15:0]      fin_val;

  // Execute datapath.
  logic [4:0]       bop, sop;
  logic [16:0]      add_s;
  logic [17:0]      adx_s;
  logic signed [18:0] sbx_q;
  logic signed [33:0] mul_p;
  logic [31:0]      shr_t, shl_t, asr_t;
  logic             big_shift;
  logic [15:0]      a_abs, b_abs;
  logic [16:0]      div_t;
  logic             div_ge;
  logic [31:0]      quo_s;
  logic [QCNT_W:0]  q_sum;
  logic [5:0]       sw_a, sw_b;
  logic             lw_pass;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_cyc_r, out_st_r, out_pc_r, out_rd_r};

  assign reg_rd = regs_r[reg_sel];

  assign bop       = word_r[4:0];
  assign sop       = word_r[9:5];
  assign add_s     = {1'b0, b_val_r} + {1'b0, a_val_r};
  assign adx_s     = {2'b00, b_val_r} + {2'b00, a_val_r} + {2'b00, ex_r};
  assign sbx_q     = $signed({3'b000, b_val_r}) - $signed({3'b000, a_val_r})
                   + $signed({{3{ex_r[15]}}, ex_r});
  assign mul_p     = $signed({(bop == OP_MLI) & b_val_r[15], b_val_r})
                   * $signed({(bop == OP_MLI) & a_val_r[15], a_val_r});
  assign big_shift = (a_val_r[15:5] != 11'd0);
  assign shr_t     = {b_val_r, 16'h0000} >> a_val_r[4:0];
  assign shl_t     = {16'h0000, b_val_r} << a_val_r[4:0];
  assign asr_t     = big_shift ? {32{b_val_r[15]}}
                   : 32'($signed({b_val_r, 16'h0000}) >>> a_val_r[4:0]);
  assign a_abs     = a_val_r[15] ? 16'(-a_val_r) : a_val_r;
  assign b_abs     = b_val_r[15] ? 16'(-b_val_r) : b_val_r;
  assign div_t     = {rem_r, dvd_r[31]};
  assign div_ge    = (div_t >= {1'b0, dvs_r});
  assign quo_s     = neg_r ? 32'(-dvd_r) : dvd_r;
  assign q_sum     = (QCNT_W+1)'(qhead_r) + (QCNT_W+1)'(qcount_r);

  dcpu_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_main_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  dcpu_ram #(.WIDTH(16), .DEPTH(QUEUE_DEPTH)) u_msg_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(qhead_r), .rdata(q_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    regs_nxt = regs_r;
    pc_nxt = pc_r; sp_nxt = sp_r; ex_nxt = ex_r; ia_nxt = ia_r;
    qhead_nxt = qhead_r; qcount_nxt = qcount_r; qon_nxt = qon_r;
    core_nxt = core_r; cyc_nxt = cyc_r;
    word_nxt = word_r; opsel_nxt = opsel_r; code_nxt = code_r;
    a_loc_nxt = a_loc_r; b_loc_nxt = b_loc_r; a_val_nxt = a_val_r; b_val_nxt = b_val_r;
    rd_nxt = rd_r; msg_nxt = msg_r; ret_fetch_nxt = ret_fetch_r; skip_n_nxt = skip_n_r;
    dvd_nxt = dvd_r; rem_nxt = rem_r; dvs_nxt = dvs_r; div_cnt_nxt = div_cnt_r;
    neg_nxt = neg_r; bneg_nxt = bneg_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_rd_nxt = out_rd_r; out_pc_nxt = out_pc_r; out_st_nxt = out_st_r;
    out_cyc_nxt = out_cyc_r;
    mem_we = 1'b0; mem_waddr = sp_r; mem_wdata = pc_r; mem_raddr = pc_r;
    q_we = 1'b0; q_wdata = msg_r;
    q_waddr = (q_sum >= (QCNT_W+1)'(QUEUE_DEPTH))
            ? QIDX_W'(q_sum - (QCNT_W+1)'(QUEUE_DEPTH)) : QIDX_W'(q_sum);
    reg_sel = code_r[2:0];
    wr_en = 1'b0; wr_loc = b_loc_r; wr_val = 16'h0000;
    fin = 1'b0; fin_loc = '{kind: LK_NONE, idx: 3'd0, addr: 16'h0000}; fin_val = 16'h0000;
    sw_a = 6'd0; sw_b = 6'd0; lw_pass = 1'b1;

    case (state_r)
      S_IDLE: begin
        reg_sel = in_tdata[2:0];
        mem_raddr = in_tdata[15:0];
        if (in_tvalid) begin
          rd_nxt = 16'h0000;
          state_nxt = S_DONE;
          case (in_tuser)
            KIND_WR_MEM: begin
              mem_we = 1'b1;
              mem_waddr = in_tdata[15:0];
              mem_wdata = in_tdata[31:16];
            end
            KIND_RD_MEM: state_nxt = S_RDMEM;
            KIND_STEP: begin
              if (core_r == CS_RUN) begin
                state_nxt = (!qon_r && qcount_r != '0) ? S_QRD : S_FETCH;
              end
            end
            KIND_INT: begin
              if (core_r == CS_RUN) begin
                msg_nxt = in_tdata[31:16];
                ret_fetch_nxt = 1'b0;
                state_nxt = S_RAISE;
              end
            end
            KIND_RD_REG: begin
              if (in_tdata[15:3] == 13'd0) begin
                rd_nxt = reg_rd;
              end else if (in_tdata[15:0] == REG_PC) begin
                rd_nxt = pc_r;
              end else if (in_tdata[15:0] == REG_SP) begin
                rd_nxt = sp_r;
              end else if (in_tdata[15:0] == REG_EX) begin
                rd_nxt = ex_r;
              end else if (in_tdata[15:0] == REG_IA) begin
                rd_nxt = ia_r;
              end
            end
            default: ;
          endcase
        end
      end

      S_RDMEM: begin
        rd_nxt = mem_rdata;
        state_nxt = S_DONE;
      end

      S_QRD: begin
        // The queue port reads the head entry continuously.
        msg_nxt = q_rdata;
        qhead_nxt = (qhead_r == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : QIDX_W'(qhead_r + 1'b1);
        qcount_nxt = QCNT_W'(qcount_r - 1'b1);
        ret_fetch_nxt = 1'b1;
        state_nxt = S_RAISE;
      end

      S_RAISE: begin
        if (ia_r == 16'h0000) begin
          state_nxt = ret_fetch_r ? S_FETCH : S_DONE;
        end else if (!qon_r) begin
          qon_nxt = 1'b1;
          mem_we = 1'b1;
          mem_waddr = 16'(sp_r - 1'b1);
          mem_wdata = pc_r;
          sp_nxt = 16'(sp_r - 1'b1);
          state_nxt = S_RAISE2;
        end else begin
          if (qcount_r >= QCNT_W'(QUEUE_DEPTH)) begin
            core_nxt = CS_FIRE;
          end else begin
            q_we = 1'b1;
            qcount_nxt = QCNT_W'(qcount_r + 1'b1);
          end
          state_nxt = ret_fetch_r ? S_FETCH : S_DONE;
        end
      end

      S_RAISE2: begin
        mem_we = 1'b1;
        mem_waddr = 16'(sp_r - 1'b1);
        mem_wdata = regs_r[0];
        sp_nxt = 16'(sp_r - 1'b1);
        pc_nxt = ia_r;
        regs_nxt[0] = msg_r;
        state_nxt = ret_fetch_r ? S_FETCH : S_DONE;
      end

      S_FETCH: begin
        mem_raddr = pc_r;
        pc_nxt = 16'(pc_r + 1'b1);
        cyc_nxt = 32'(cyc_r + 1'b1);
        state_nxt = S_FETCH_W;
      end

      S_FETCH_W: begin
        word_nxt = mem_rdata;
        if (mem_rdata[9:0] == 10'd0) begin
          core_nxt = CS_HALT;
          state_nxt = S_DONE;
        end else begin
          opsel_nxt = 1'b0;
          code_nxt = mem_rdata[15:10];
          state_nxt = S_OP;
        end
      end

      S_OP: begin
        if (code_r < 6'h08) begin
          fin = 1'b1;
          fin_loc = '{kind: LK_REG, idx: code_r[2:0], addr: 16'h0000};
          fin_val = reg_rd;
        end else if (code_r < 6'h10) begin
          mem_raddr = reg_rd;
          fin_loc = '{kind: LK_MEM, idx: 3'd0, addr: reg_rd};
          state_nxt = S_OP_MEM;
        end else if (needs_word(code_r)) begin
          mem_raddr = pc_r;
          pc_nxt = 16'(pc_r + 1'b1);
          cyc_nxt = 32'(cyc_r + 1'b1);
          state_nxt = S_OP_NW;
        end else if (code_r == OPD_PUSH_POP) begin
          // Push as a destination, pop as a source.
          if (opsel_r) begin
            mem_raddr = 16'(sp_r - 1'b1);
            sp_nxt = 16'(sp_r - 1'b1);
          end else begin
            mem_raddr = sp_r;
            sp_nxt = 16'(sp_r + 1'b1);
          end
          fin_loc = '{kind: LK_MEM, idx: 3'd0, addr: mem_raddr};
          state_nxt = S_OP_MEM;
        end else if (code_r == OPD_PEEK) begin
          mem_raddr = sp_r;
          fin_loc = '{kind: LK_MEM, idx: 3'd0, addr: sp_r};
          state_nxt = S_OP_MEM;
        end else if (code_r == OPD_SP) begin
          fin = 1'b1;
          fin_loc = '{kind: LK_SP, idx: 3'd0, addr: 16'h0000};
          fin_val = sp_r;
        end else if (code_r == OPD_PC) begin
          fin = 1'b1;
          fin_loc = '{kind: LK_PC, idx: 3'd0, addr: 16'h0000};
          fin_val = pc_r;
        end else if (code_r == OPD_EX) begin
          fin = 1'b1;
          fin_loc = '{kind: LK_EX, idx: 3'd0, addr: 16'h0000};
          fin_val = ex_r;
        end else begin
          fin = 1'b1;
          fin_val = 16'(16'({10'd0, code_r}) - 16'({10'd0, OPD_LIT_BASE}));
        end
        if (!fin && state_nxt == S_OP_MEM) begin
          if (opsel_r) begin
            b_loc_nxt = fin_loc;
          end else begin
            a_loc_nxt = fin_loc;
          end
        end
      end

      S_OP_NW: begin
        if (code_r == OPD_LIT_NW) begin
          fin = 1'b1;
          fin_val = mem_rdata;
        end else begin
          if (code_r == OPD_PICK) begin
            mem_raddr = 16'(sp_r + mem_rdata);
          end else if (code_r == OPD_IND_NW) begin
            mem_raddr = mem_rdata;
          end else begin
            mem_raddr = 16'(reg_rd + mem_rdata);
          end
          fin_loc = '{kind: LK_MEM, idx: 3'd0, addr: mem_raddr};
          if (opsel_r) begin
            b_loc_nxt = fin_loc;
          end else begin
            a_loc_nxt = fin_loc;
          end
          state_nxt = S_OP_MEM;
        end
      end

      S_OP_MEM: begin
        fin = 1'b1;
        fin_loc = opsel_r ? b_loc_r : a_loc_r;
        fin_val = mem_rdata;
      end

      S_EXEC: begin
        if (bop != 5'd0) begin
          if (basic_cost(bop) == 2'd0) begin
            core_nxt = CS_HALT;
            state_nxt = S_DONE;
          end else begin
            cyc_nxt = 32'(cyc_r + 32'(basic_cost(bop)) - 1'b1);
            state_nxt = S_DONE;
            wr_en = 1'b1;
            case (bop)
              OP_SET: wr_val = a_val_r;
              OP_ADD: begin
                wr_val = add_s[15:0];
                ex_nxt = {15'd0, add_s[16]};
              end
              OP_SUB: begin
                wr_val = 16'(b_val_r - a_val_r);
                ex_nxt = (a_val_r > b_val_r) ? 16'hFFFF : 16'h0000;
              end
              OP_MUL, OP_MLI: begin
                wr_val = mul_p[15:0];
                ex_nxt = mul_p[31:16];
              end
              OP_DIV, OP_DVI, OP_MOD, OP_MDI: begin
                if (a_val_r == 16'h0000) begin
                  wr_val = 16'h0000;
                  if (bop == OP_DIV || bop == OP_DVI) begin
                    ex_nxt = 16'h0000;
                  end
                end else begin
                  wr_en = 1'b0;
                  if (bop == OP_DIV) begin
                    dvd_nxt = {b_val_r, 16'h0000};
                    dvs_nxt = a_val_r;
                  end else if (bop == OP_MOD) begin
                    dvd_nxt = {16'h0000, b_val_r};
                    dvs_nxt = a_val_r;
                  end else if (bop == OP_DVI) begin
                    dvd_nxt = {b_abs, 16'h0000};
                    dvs_nxt = a_abs;
                  end else begin
                    dvd_nxt = {16'h0000, b_abs};
                    dvs_nxt = a_abs;
                  end
                  neg_nxt = (bop == OP_DVI) && (b_val_r[15] ^ a_val_r[15]);
                  bneg_nxt = b_val_r[15];
                  rem_nxt = 16'h0000;
                  div_cnt_nxt = 5'd0;
                  state_nxt = S_DIV;
                end
              end
              OP_AND: wr_val = b_val_r & a_val_r;
              OP_BOR: wr_val = b_val_r | a_val_r;
              OP_XOR: wr_val = b_val_r ^ a_val_r;
              OP_SHR: begin
                wr_val = big_shift ? 16'h0000 : shr_t[31:16];
                ex_nxt = big_shift ? 16'h0000 : shr_t[15:0];
              end
              OP_ASR: begin
                wr_val = asr_t[31:16];
                ex_nxt = asr_t[15:0];
              end
              OP_SHL: begin
                wr_val = big_shift ? 16'h0000 : shl_t[15:0];
                ex_nxt = big_shift ? 16'h0000 : shl_t[31:16];
              end
              OP_IFB, OP_IFC, OP_IFE, OP_IFN, OP_IFG, OP_IFA, OP_IFL, OP_IFU: begin
                wr_en = 1'b0;
                case (bop)
                  OP_IFB: lw_pass = (b_val_r & a_val_r) != 16'h0000;
                  OP_IFC: lw_pass = (b_val_r & a_val_r) == 16'h0000;
                  OP_IFE: lw_pass = b_val_r == a_val_r;
                  OP_IFN: lw_pass = b_val_r != a_val_r;
                  OP_IFG: lw_pass = b_val_r > a_val_r;
                  OP_IFA: lw_pass = $signed(b_val_r) > $signed(a_val_r);
                  OP_IFL: lw_pass = b_val_r < a_val_r;
                  default: lw_pass = $signed(b_val_r) < $signed(a_val_r);
                endcase
                if (!lw_pass) begin
                  skip_n_nxt = 16'h0000;
                  state_nxt = S_SKIP;
                end
              end
              OP_ADX: begin
                wr_val = adx_s[15:0];
                ex_nxt = (adx_s[17:16] != 2'b00) ? 16'h0001 : 16'h0000;
              end
              OP_SBX: begin
                wr_val = sbx_q[15:0];
                ex_nxt = (sbx_q < 0) ? 16'hFFFF
                       : (sbx_q > 19'sd65535) ? 16'h0001 : 16'h0000;
              end
              default: wr_val = a_val_r;
            endcase
          end
        end else begin
          if (special_cost(sop) == 3'd0) begin
            core_nxt = CS_HALT;
            state_nxt = S_DONE;
          end else begin
            cyc_nxt = 32'(cyc_r + 32'(special_cost(sop)) - 1'b1);
            state_nxt = S_DONE;
            wr_loc = a_loc_r;
            case (sop)
              SOP_JSR: begin
                mem_we = 1'b1;
                mem_waddr = 16'(sp_r - 1'b1);
                mem_wdata = pc_r;
                sp_nxt = 16'(sp_r - 1'b1);
                pc_nxt = a_val_r;
              end
              SOP_INT: begin
                msg_nxt = a_val_r;
                ret_fetch_nxt = 1'b0;
                state_nxt = S_RAISE;
              end
              SOP_IAG: begin
                wr_en = 1'b1;
                wr_val = ia_r;
              end
              SOP_IAS: ia_nxt = a_val_r;
              SOP_RFI: begin
                qon_nxt = 1'b0;
                mem_raddr = sp_r;
                sp_nxt = 16'(sp_r + 1'b1);
                state_nxt = S_RFI1;
              end
              SOP_IAQ: qon_nxt = (a_val_r != 16'h0000);
              SOP_HWN: wr_en = 1'b1;
              SOP_HWQ: begin
                regs_nxt[0] = 16'h0000;
                regs_nxt[1] = 16'h0000;
                regs_nxt[2] = 16'h0000;
                regs_nxt[3] = 16'h0000;
                regs_nxt[4] = 16'h0000;
              end
              default: ;
            endcase
          end
        end
      end

      S_DIV: begin
        rem_nxt = div_ge ? 16'(div_t - {1'b0, dvs_r}) : div_t[15:0];
        dvd_nxt = {dvd_r[30:0], div_ge};
        div_cnt_nxt = 5'(div_cnt_r + 1'b1);
        if (div_cnt_r == 5'd31) begin
          state_nxt = S_DIV_WB;
        end
      end

      S_DIV_WB: begin
        wr_en = 1'b1;
        state_nxt = S_DONE;
        case (bop)
          OP_DIV: begin
            wr_val = dvd_r[31:16];
            ex_nxt = dvd_r[15:0];
          end
          OP_DVI: begin
            wr_val = neg_r ? 16'(-dvd_r[31:16]) : dvd_r[31:16];
            ex_nxt = quo_s[15:0];
          end
          OP_MOD: wr_val = rem_r;
          default: wr_val = bneg_r ? 16'(-rem_r) : rem_r;
        endcase
      end

      S_SKIP: begin
        mem_raddr = pc_r;
        state_nxt = S_SKIP_W;
      end

      S_SKIP_W: begin
        sw_a = mem_rdata[15:10];
        sw_b = {1'b0, mem_rdata[9:5]};
        cyc_nxt = 32'(cyc_r + 1'b1);
        pc_nxt = 16'(pc_r + 16'd1 + 16'(needs_word(sw_a))
                 + 16'((mem_rdata[4:0] != 5'd0) && needs_word(sw_b)));
        skip_n_nxt = 16'(skip_n_r + 1'b1);
        // Only further conditionals extend the chain.
        if (mem_rdata[4:0] >= OP_IFB && mem_rdata[4:0] <= OP_IFU && skip_n_r != 16'hFFFF) begin
          state_nxt = S_SKIP;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_RFI1: begin
        regs_nxt[0] = mem_rdata;
        mem_raddr = sp_r;
        sp_nxt = 16'(sp_r + 1'b1);
        state_nxt = S_RFI2;
      end

      S_RFI2: begin
        pc_nxt = mem_rdata;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt = rd_r;
          out_pc_nxt = pc_r;
          out_st_nxt = core_r;
          out_cyc_nxt = cyc_r;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // An operand has been resolved: move on to the destination or execute.
    if (fin) begin
      if (opsel_r) begin
        b_loc_nxt = fin_loc;
        b_val_nxt = fin_val;
        state_nxt = S_EXEC;
      end else begin
        a_loc_nxt = fin_loc;
        a_val_nxt = fin_val;
        if (bop != 5'd0) begin
          opsel_nxt = 1'b1;
          code_nxt = {1'b0, word_r[9:5]};
          state_nxt = S_OP;
        end else begin
          state_nxt = S_EXEC;
        end
      end
    end

    // The location write comes after the case so that it wins over the EX update.
    if (wr_en) begin
      case (wr_loc.kind)
        LK_REG: regs_nxt[wr_loc.idx] = wr_val;
        LK_PC:  pc_nxt = wr_val;
        LK_SP:  sp_nxt = wr_val;
        LK_EX:  ex_nxt = wr_val;
        LK_MEM: begin
          mem_we = 1'b1;
          mem_waddr = wr_loc.addr;
          mem_wdata = wr_val;
        end
        default: ;
      endcase
    end
    if (state_r == S_EXEC && bop == OP_STI) begin
      regs_nxt[6] = 16'(regs_nxt[6] + 1'b1);
      regs_nxt[7] = 16'(regs_nxt[7] + 1'b1);
    end else if (state_r == S_EXEC && bop == OP_STD) begin
      regs_nxt[6] = 16'(regs_nxt[6] - 1'b1);
      regs_nxt[7] = 16'(regs_nxt[7] - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < 8; i++) begin
        regs_r[i] <= 16'h0000;
      end
      pc_r <= 16'h0000;
      sp_r <= 16'h0000;
      ex_r <= 16'h0000;
      ia_r <= 16'h0000;
      qhead_r <= '0;
      qcount_r <= '0;
      qon_r <= 1'b0;
      core_r <= CS_RUN;
      cyc_r <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      regs_r <= regs_nxt;
      pc_r <= pc_nxt;
      sp_r <= sp_nxt;
      ex_r <= ex_nxt;
      ia_r <= ia_nxt;
      qhead_r <= qhead_nxt;
      qcount_r <= qcount_nxt;
      qon_r <= qon_nxt;
      core_r <= core_nxt;
      cyc_r <= cyc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    word_r <= word_nxt;
    opsel_r <= opsel_nxt;
    code_r <= code_nxt;
    a_loc_r <= a_loc_nxt;
    b_loc_r <= b_loc_nxt;
    a_val_r <= a_val_nxt;
    b_val_r <= b_val_nxt;
    rd_r <= rd_nxt;
    msg_r <= msg_nxt;
    ret_fetch_r <= ret_fetch_nxt;
    skip_n_r <= skip_n_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    div_cnt_r <= div_cnt_nxt;
    neg_r <= neg_nxt;
    bneg_r <= bneg_nxt;
    out_rd_r <= out_rd_nxt;
    out_pc_r <= out_pc_nxt;
    out_st_r <= out_st_nxt;
    out_cyc_r <= out_cyc_nxt;
  end

endmodule

@@ hdl/dcpu_checker.sv @@
// Port-level checks for the DCPU-16 core, bound to the top level.
module dcpu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // A result register is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // One transaction is worked on at a time, so the input closes after each one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[71:66] == 6'd0)
    else $error("result padding not zero");

endmodule

bind dcpu16_processor_core_unit dcpu_checker u_dcpu_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
